/* sv/paxacc_pkg.sv */
// Shared types, codes and default sizes for the Paxos acceptor instance core.
package paxacc_pkg;

    localparam int FIELD_BITS = 64;
    localparam int OP_BITS = 3;
    localparam int STATUS_BITS = 2;

    localparam int BALLOT_BITS_DEFAULT = 64;
    localparam int ID_BITS_DEFAULT = 64;

    typedef enum logic [OP_BITS-1:0] {
        OP_PREPARE = 3'd0,
        OP_ACCEPT  = 3'd1,
        OP_VOTE    = 3'd2,
        OP_COMMIT  = 3'd3,
        OP_QUERY   = 3'd4,
        OP_RESET   = 3'd5,
        OP_LOAD    = 3'd6
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK            = 2'd0,
        ST_STALE         = 2'd1,
        ST_UNKNOWN_VALUE = 2'd2,
        ST_NOT_COMMITTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [FIELD_BITS-1:0] ballot;
        logic [FIELD_BITS-1:0] value_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  promised_ballot;
        logic [FIELD_BITS-1:0]  voted_ballot;
        logic [FIELD_BITS-1:0]  value_id_out;
        logic                   recovered_vote;
        logic [FIELD_BITS-1:0]  recovered_ballot;
    } rsp_t;

endpackage

/* sv/paxacc_state.sv */
// Acceptor state registers and the per-request decision logic.
module paxacc_state #(
    parameter int BALLOT_BITS = paxacc_pkg::BALLOT_BITS_DEFAULT,
    parameter int ID_BITS = paxacc_pkg::ID_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  paxacc_pkg::req_t  req,
    output paxacc_pkg::rsp_t  rsp
);

    logic [BALLOT_BITS-1:0] promised_reg, promised_next;
    logic [BALLOT_BITS-1:0] voted_reg, voted_next;
    logic [ID_BITS-1:0]     last_value_reg, last_value_next;
    logic                   pending_valid_reg, pending_valid_next;
    logic [BALLOT_BITS-1:0] pending_ballot_reg, pending_ballot_next;
    logic [ID_BITS-1:0]     pending_value_reg, pending_value_next;
    logic                   committed_reg, committed_next;

    logic [BALLOT_BITS-1:0] b;
    logic [ID_BITS-1:0]     v;
    logic                   report_prom;
    logic                   report_vote;
    logic [BALLOT_BITS-1:0] voted_max;

    assign b = req.ballot[BALLOT_BITS-1:0];
    assign v = req.value_id[ID_BITS-1:0];
    assign voted_max = (b > voted_reg) ? b : voted_reg;

    always_comb
    begin
        promised_next       = promised_reg;
        voted_next          = voted_reg;
        last_value_next     = last_value_reg;
        pending_valid_next  = pending_valid_reg;
        pending_ballot_next = pending_ballot_reg;
        pending_value_next  = pending_value_reg;
        committed_next      = committed_reg;
        report_prom         = 1'b1;
        report_vote         = 1'b0;
        rsp                 = '0;
        rsp.status          = paxacc_pkg::ST_OK;

        case (paxacc_pkg::op_t'(req.op))
            paxacc_pkg::OP_PREPARE:
            begin
                if (b > promised_reg)
                begin
                    promised_next = b;
                    report_vote   = 1'b1;
                end
                else
                begin
                    rsp.status = paxacc_pkg::ST_STALE;
                end
            end
            paxacc_pkg::OP_ACCEPT:
            begin
                if (b < promised_reg)
                begin
                    rsp.status = paxacc_pkg::ST_STALE;
                end
                else
                begin
                    voted_next      = voted_max;
                    last_value_next = v;
                    // A parked vote for exactly this proposal is resent now.
                    if (pending_valid_reg && pending_ballot_reg == b
                        && pending_value_reg == v)
                    begin
                        rsp.recovered_vote   = 1'b1;
                        rsp.recovered_ballot = paxacc_pkg::FIELD_BITS'(b);
                    end
                    pending_valid_next  = 1'b0;
                    pending_ballot_next = '0;
                    pending_value_next  = '0;
                end
            end
            paxacc_pkg::OP_VOTE:
            begin
                if (b < promised_reg)
                begin
                    rsp.status = paxacc_pkg::ST_STALE;
                end
                else if (last_value_reg != v)
                begin
                    pending_valid_next  = 1'b1;
                    pending_ballot_next = b;
                    pending_value_next  = v;
                    rsp.status          = paxacc_pkg::ST_UNKNOWN_VALUE;
                    report_prom         = 1'b0;
                end
                else
                begin
                    voted_next = voted_max;
                end
            end
            paxacc_pkg::OP_COMMIT:
            begin
                if (last_value_reg != v)
                begin
                    rsp.status = paxacc_pkg::ST_UNKNOWN_VALUE;
                end
                else
                begin
                    committed_next = 1'b1;
                end
            end
            paxacc_pkg::OP_QUERY:
            begin
                if (committed_reg)
                begin
                    report_vote = 1'b1;
                end
                else
                begin
                    rsp.status = paxacc_pkg::ST_NOT_COMMITTED;
                end
            end
            paxacc_pkg::OP_RESET:
            begin
                promised_next       = '0;
                voted_next          = '0;
                last_value_next     = '0;
                pending_valid_next  = 1'b0;
                pending_ballot_next = '0;
                pending_value_next  = '0;
                committed_next      = 1'b0;
            end
            paxacc_pkg::OP_LOAD:
            begin
                promised_next       = b;
                voted_next          = b;
                last_value_next     = v;
                pending_valid_next  = 1'b0;
                pending_ballot_next = '0;
                pending_value_next  = '0;
                committed_next      = 1'b1;
            end
            default:
            begin
                report_prom = 1'b0;
            end
        endcase

        // Prepare and query report the vote as it stood before the request.
        if (report_vote)
        begin
            rsp.voted_ballot = paxacc_pkg::FIELD_BITS'(voted_reg);
            rsp.value_id_out = paxacc_pkg::FIELD_BITS'(last_value_reg);
        end
        if (report_prom)
        begin
            rsp.promised_ballot = paxacc_pkg::FIELD_BITS'(promised_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promised_reg       <= '0;
            voted_reg          <= '0;
            last_value_reg     <= '0;
            pending_valid_reg  <= 1'b0;
            pending_ballot_reg <= '0;
            pending_value_reg  <= '0;
            committed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            promised_reg       <= promised_next;
            voted_reg          <= voted_next;
            last_value_reg     <= last_value_next;
            pending_valid_reg  <= pending_valid_next;
            pending_ballot_reg <= pending_ballot_next;
            pending_value_reg  <= pending_value_next;
            committed_reg      <= committed_next;
        end
    end

endmodule

/* sv/paxos_acceptor_instance_core.sv */
// A request is held in the input register, its response in the response register.
// Throughput: one request per cycle, sustained while the response side does not stall.
// The input register and the response register form a two-stage pipe; state updates
// in the cycle a request moves from the input register into the response register.
// Reset (rst_n low) clears the acceptor state and empties both pipeline stages.
module paxos_acceptor_instance_core #(
    parameter int BALLOT_BITS = paxacc_pkg::BALLOT_BITS_DEFAULT,
    parameter int ID_BITS = paxacc_pkg::ID_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  paxacc_pkg::req_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output paxacc_pkg::rsp_t  rsp
);

    // Input stage: holds one request beat until it can be decided.
    logic             in_valid_reg;
    paxacc_pkg::req_t in_reg;

    // Response stage: holds one finished response beat until it is taken.
    logic             out_valid_reg;
    paxacc_pkg::rsp_t out_reg;

    paxacc_pkg::rsp_t rsp_next;
    logic             advance;
    logic             fire;

    // The response register can take a new beat when it is empty or being
    // drained this cycle. A request in the input register is decided then,
    // and the acceptor state is updated in that same edge, so the next
    // request right behind it sees the updated state.
    assign advance = !out_valid_reg || !rsp_stall;
    assign fire    = in_valid_reg && advance;

    // The input register is blocked only while it holds a beat that cannot
    // move on.
    assign req_stall = in_valid_reg && !advance;

    paxacc_state #(
        .BALLOT_BITS (BALLOT_BITS),
        .ID_BITS     (ID_BITS)
    ) u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_reg),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    // The input stage only pushes back when a finished beat is stuck at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while the response stage could drain");

    // A recovered vote is only ever resent with a successful accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.recovered_vote) |-> (rsp.status == paxacc_pkg::ST_OK))
        else $error("recovered vote reported on a failed request");

    // A rejected or uncommitted request never reports vote data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == paxacc_pkg::ST_STALE
                       || rsp.status == paxacc_pkg::ST_NOT_COMMITTED))
        |-> (rsp.voted_ballot == '0 && rsp.value_id_out == '0
             && !rsp.recovered_vote))
        else $error("vote data reported on a rejected request");

    // A request sitting in the input stage reaches the response stage on the
    // next edge whenever the response stage was free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> rsp_valid)
        else $error("decided request did not reach the response stage");
`endif

endmodule

/* tb/tb_paxos_acceptor_instance_core.sv */
// Self-checking testbench for the Paxos acceptor instance core with a built-in acceptor predictor.
module tb_paxos_acceptor_instance_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code 7 has no meaning. The acceptor must answer it with an all-zero
    // beat and leave its state alone.
    localparam logic [paxacc_pkg::OP_BITS-1:0] OP_UNUSED = 3'd7;
    localparam logic [paxacc_pkg::FIELD_BITS-1:0] ALL_ONES = '1;

    // The slowest correct run is about 2000 beats, each held back by sender
    // gaps and receiver stalls. This limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 670;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    paxacc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    paxacc_pkg::rsp_t rsp;

    // Requests wait here until the driver presents them. Each accepted
    // request leaves its predicted response in the second queue, oldest first.
    paxacc_pkg::req_t pending_reqs[$];
    paxacc_pkg::rsp_t expected_rsps[$];

    // These are set by the stimulus process for each phase of the run.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    // This flag is set when a request beat was taken at the last rising edge.
    // The driver reads it at the following falling edge.
    logic req_fire = 1'b0;

    int mismatches = 0;
    int rsp_count = 0;
    int cycles = 0;

    // This is the predictor's own copy of the acceptor state.
    logic [paxacc_pkg::FIELD_BITS-1:0] promised_q = '0;
    logic [paxacc_pkg::FIELD_BITS-1:0] voted_q = '0;
    logic [paxacc_pkg::FIELD_BITS-1:0] last_value_q = '0;
    logic                              park_valid = 1'b0;
    logic [paxacc_pkg::FIELD_BITS-1:0] park_ballot = '0;
    logic [paxacc_pkg::FIELD_BITS-1:0] park_value = '0;
    logic                              committed_q = 1'b0;

    paxos_acceptor_instance_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // The predictor applies one request to the acceptor state and returns
    // the response that the request must produce.
    function automatic paxacc_pkg::rsp_t acceptor_predict(paxacc_pkg::req_t r);
        paxacc_pkg::rsp_t o;
        logic show_promise;
        o = '0;
        show_promise = 1'b1;
        case (r.op)
            paxacc_pkg::OP_PREPARE:
            begin
                // A promise needs a strictly higher ballot. Ballot zero can never win.
                if (r.ballot > promised_q)
                begin
                    promised_q = r.ballot;
                    o.voted_ballot = voted_q;
                    o.value_id_out = last_value_q;
                end
                else
                begin
                    o.status = paxacc_pkg::ST_STALE;
                end
            end
            paxacc_pkg::OP_ACCEPT:
            begin
                if (r.ballot < promised_q)
                begin
                    o.status = paxacc_pkg::ST_STALE;
                end
                else
                begin
                    if (r.ballot > voted_q)
                        voted_q = r.ballot;
                    last_value_q = r.value_id;
                    // A parked vote is resent only on an exact match. It is
                    // dropped whether or not it matched.
                    if (park_valid)
                    begin
                        if (park_ballot == r.ballot && park_value == r.value_id)
                        begin
                            o.recovered_vote = 1'b1;
                            o.recovered_ballot = r.ballot;
                        end
                        park_valid = 1'b0;
                        park_ballot = '0;
                        park_value = '0;
                    end
                end
            end
            paxacc_pkg::OP_VOTE:
            begin
                if (r.ballot < promised_q)
                begin
                    o.status = paxacc_pkg::ST_STALE;
                end
                else if (last_value_q != r.value_id)
                begin
                    // An unknown value parks the vote and replaces an older one.
                    park_valid = 1'b1;
                    park_ballot = r.ballot;
                    park_value = r.value_id;
                    o.status = paxacc_pkg::ST_UNKNOWN_VALUE;
                    show_promise = 1'b0;
                end
                else if (r.ballot > voted_q)
                begin
                    voted_q = r.ballot;
                end
            end
            paxacc_pkg::OP_COMMIT:
            begin
                if (last_value_q != r.value_id)
                    o.status = paxacc_pkg::ST_UNKNOWN_VALUE;
                else
                    committed_q = 1'b1;
            end
            paxacc_pkg::OP_QUERY:
            begin
                if (committed_q)
                begin
                    o.voted_ballot = voted_q;
                    o.value_id_out = last_value_q;
                end
                else
                begin
                    o.status = paxacc_pkg::ST_NOT_COMMITTED;
                end
            end
            paxacc_pkg::OP_RESET, paxacc_pkg::OP_LOAD:
            begin
                promised_q = '0;
                voted_q = '0;
                last_value_q = '0;
                park_valid = 1'b0;
                park_ballot = '0;
                park_value = '0;
                committed_q = 1'b0;
                if (r.op == paxacc_pkg::OP_LOAD)
                begin
                    promised_q = r.ballot;
                    voted_q = r.ballot;
                    last_value_q = r.value_id;
                    committed_q = 1'b1;
                end
            end
            default:
            begin
                show_promise = 1'b0;
            end
        endcase
        if (show_promise)
            o.promised_ballot = promised_q;
        return o;
    endfunction

    function automatic logic [paxacc_pkg::FIELD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_req(input logic [paxacc_pkg::OP_BITS-1:0] op,
                             input logic [paxacc_pkg::FIELD_BITS-1:0] b,
                             input logic [paxacc_pkg::FIELD_BITS-1:0] v);
        paxacc_pkg::req_t r;
        r.op = op;
        r.ballot = b;
        r.value_id = v;
        pending_reqs.push_back(r);
    endtask

    // A session opens with a reset or a load. It then runs a proposer round
    // whose ballots creep upward from a base. Value ids come from a small pool
    // so that votes and commits often match. Stale ballots, vote recovery and
    // some fully random beats are mixed in.
    task automatic queue_session();
        logic [paxacc_pkg::FIELD_BITS-1:0] b;
        logic [paxacc_pkg::FIELD_BITS-1:0] v;
        int steps;
        int pick;
        if ($urandom_range(3) == 0)
            b = rand_word();
        else
            b = paxacc_pkg::FIELD_BITS'($urandom_range(1, 500));
        if ($urandom_range(1) == 0)
            queue_req(paxacc_pkg::OP_RESET, rand_word(), rand_word());
        else
            queue_req(paxacc_pkg::OP_LOAD, b, paxacc_pkg::FIELD_BITS'($urandom_range(0, 3)));
        steps = $urandom_range(4, 24);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            v = paxacc_pkg::FIELD_BITS'($urandom_range(0, 3));
            if (pick < 15)
            begin
                b = b + paxacc_pkg::FIELD_BITS'($urandom_range(0, 2));
                queue_req(paxacc_pkg::OP_PREPARE, b, rand_word());
            end
            else if (pick < 30)
            begin
                queue_req(paxacc_pkg::OP_ACCEPT,
                          b + paxacc_pkg::FIELD_BITS'($urandom_range(0, 1)), v);
            end
            else if (pick < 45)
            begin
                queue_req(paxacc_pkg::OP_VOTE,
                          b + paxacc_pkg::FIELD_BITS'($urandom_range(0, 1)), v);
            end
            else if (pick < 55)
            begin
                // Park a vote, then accept the same ballot and value so that
                // the parked vote is recovered.
                v = paxacc_pkg::FIELD_BITS'($urandom_range(0, 7));
                queue_req(paxacc_pkg::OP_VOTE, b, v);
                queue_req(paxacc_pkg::OP_ACCEPT, b, v);
            end
            else if (pick < 66)
            begin
                queue_req(paxacc_pkg::OP_COMMIT, rand_word(), v);
            end
            else if (pick < 77)
            begin
                queue_req(paxacc_pkg::OP_QUERY, rand_word(), rand_word());
            end
            else if (pick < 87)
            begin
                queue_req(paxacc_pkg::OP_BITS'($urandom_range(paxacc_pkg::OP_PREPARE,
                                                             paxacc_pkg::OP_VOTE)),
                          b - paxacc_pkg::FIELD_BITS'($urandom_range(1, 3)), v);
            end
            else if (pick < 95)
            begin
                queue_req(paxacc_pkg::OP_BITS'($urandom_range(0, 7)), rand_word(), rand_word());
            end
            else if (pick < 98)
            begin
                queue_req(paxacc_pkg::OP_RESET, rand_word(), rand_word());
            end
            else
            begin
                b = rand_word();
                queue_req(paxacc_pkg::OP_LOAD, b, rand_word());
            end
        end
    endtask

    task automatic check_field(input string what,
                               input logic [paxacc_pkg::FIELD_BITS-1:0] got,
                               input logic [paxacc_pkg::FIELD_BITS-1:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in response %0d, %s: expected %h, got %h",
                         rsp_count, what, want, got);
        end
    endtask

    // The driver works on the falling edge. A beat that is still stalled keeps
    // its payload. Otherwise the driver either presents the next pending
    // request or idles, as the current phase sets the odds. Stalls of the
    // response side are drawn fresh every cycle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_fire)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // The monitor works on the rising edge. The values it reads are the ones
    // that were stable before the edge. An accepted request is run through
    // the predictor at once, so the expected responses line up in request
    // order. An accepted response is compared with the oldest expectation.
    always @(posedge clk)
    begin
        paxacc_pkg::rsp_t want;
        req_fire = rst_n && req_valid && !req_stall;
        if (req_fire)
            expected_rsps.push_back(acceptor_predict(req));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response beat %0d arrived with none expected: %p",
                             rsp_count, rsp);
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("status", paxacc_pkg::FIELD_BITS'(rsp.status),
                            paxacc_pkg::FIELD_BITS'(want.status));
                check_field("promised_ballot", rsp.promised_ballot, want.promised_ballot);
                check_field("voted_ballot", rsp.voted_ballot, want.voted_ballot);
                check_field("value_id_out", rsp.value_id_out, want.value_id_out);
                check_field("recovered_vote", paxacc_pkg::FIELD_BITS'(rsp.recovered_vote),
                            paxacc_pkg::FIELD_BITS'(want.recovered_vote));
                check_field("recovered_ballot", rsp.recovered_ballot, want.recovered_ballot);
            end
            rsp_count++;
        end
    end

    // This is the watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** paxos_acceptor_instance_core: FAILED **");
            $finish;
        end
    end

    // The stimulus runs in three phases. In the first, the sender idles more
    // rarely than the receiver stalls. In the second, the two are swapped. In
    // the third, nothing idles. Between phases the sender holds off until
    // every expected response has come back, so the pipe drains completely
    // at least twice.
    initial
    begin
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 49 : 0;
            rsp_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 29 : 0;
            if (phase == 0)
            begin
                // The directed opening starts from the cleared state.
                queue_req(paxacc_pkg::OP_QUERY, '0, '0);            // not committed yet
                queue_req(paxacc_pkg::OP_PREPARE, '0, '0);          // ballot zero never wins
                queue_req(paxacc_pkg::OP_PREPARE, 64'd5, 64'd1);
                queue_req(paxacc_pkg::OP_PREPARE, 64'd5, 64'd1);    // equal ballot is stale
                queue_req(paxacc_pkg::OP_ACCEPT, 64'd4, 64'd1);     // below the promise
                queue_req(paxacc_pkg::OP_ACCEPT, 64'd5, ALL_ONES);
                queue_req(paxacc_pkg::OP_VOTE, 64'd5, 64'd7);       // unknown value parks
                queue_req(paxacc_pkg::OP_ACCEPT, 64'd5, 64'd7);     // parked vote recovered
                queue_req(paxacc_pkg::OP_VOTE, 64'd3, 64'd7);       // stale vote
                queue_req(paxacc_pkg::OP_VOTE, 64'd6, 64'd7);       // raises the voted ballot
                queue_req(paxacc_pkg::OP_COMMIT, '0, 64'd8);        // wrong value
                queue_req(paxacc_pkg::OP_COMMIT, '0, 64'd7);
                queue_req(paxacc_pkg::OP_QUERY, '0, '0);
                queue_req(OP_UNUSED, ALL_ONES, ALL_ONES);
                queue_req(paxacc_pkg::OP_LOAD, ALL_ONES, ALL_ONES);
                queue_req(paxacc_pkg::OP_PREPARE, ALL_ONES, '0);    // nothing is above the top
                queue_req(paxacc_pkg::OP_ACCEPT, ALL_ONES, '0);
                queue_req(paxacc_pkg::OP_VOTE, ALL_ONES, 64'd5);
                queue_req(paxacc_pkg::OP_ACCEPT, ALL_ONES, 64'd6);  // mismatch drops the vote
                queue_req(paxacc_pkg::OP_ACCEPT, ALL_ONES, 64'd5);  // nothing left to recover
                queue_req(paxacc_pkg::OP_QUERY, '0, '0);
                queue_req(paxacc_pkg::OP_RESET, ALL_ONES, ALL_ONES);
                queue_req(paxacc_pkg::OP_QUERY, ALL_ONES, ALL_ONES);
            end
            while (pending_reqs.size() < PHASE_ITEMS)
                queue_session();
            if (phase == 0)
            begin
                repeat (8) @(posedge clk);
                @(negedge clk);
                rst_n = 1'b1;
            end
            while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
                @(posedge clk);
        end
        // The pipe is two stages deep, so any stray beat shows up before the final check.
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** paxos_acceptor_instance_core: PASSED **");
        else
            $display("** paxos_acceptor_instance_core: FAILED **");
        $finish;
    end

endmodule
